// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_ON(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_ON(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/core/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// Fit block allocator package
// Sequencer states, register map, mode and kind codes, fixed field widths.
// ----------------------------------------------------------------------------
package fba_pkg;

  // Fixed widths of the request and result fields
  localparam int unsigned SIZE_IN_W = 16;
  localparam int unsigned IDX_IN_W  = 3;
  localparam int unsigned SUM_W     = 19;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned PADDR_W   = 2;
  localparam int unsigned PDATA_W   = 32;

  // Register map (byte addresses)
  localparam logic [PADDR_W-1:0] REG_FIT_MODE = 2'd0;

  // Placement policies; the fourth code grants nothing
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  // Request kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_ALLOC = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_WR,
    S_SCAN,
    S_ALLOC_WR,
    S_RESULT
  } fba_state_e;

endpackage

// ===== rtl/core/fba_block_store.sv =====
// ----------------------------------------------------------------------------
// Fit block allocator block store
// Free-size and capacity memories with per-entry valid bits, one write port
// and one registered read port; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module fba_block_store #(
  parameter int unsigned NUM_BLOCKS = 8,
  parameter int unsigned SIZE_BITS  = 16,
  localparam int unsigned IDX_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [IDX_W-1:0]     rd_addr_i,
  output logic [SIZE_BITS-1:0] rd_free_o,
  output logic [SIZE_BITS-1:0] rd_cap_o,
  input  logic                 wr_en_i,
  input  logic                 wr_cap_i,
  input  logic [IDX_W-1:0]     wr_addr_i,
  input  logic [SIZE_BITS-1:0] wr_free_i,
  input  logic [SIZE_BITS-1:0] wr_cap_data_i
);

  logic [SIZE_BITS-1:0]  free_mem [NUM_BLOCKS];
  logic [SIZE_BITS-1:0]  cap_mem  [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] free_vld_q;
  logic [NUM_BLOCKS-1:0] cap_vld_q;
  logic [SIZE_BITS-1:0]  rd_free_q;
  logic [SIZE_BITS-1:0]  rd_cap_q;
  logic                  rd_free_vld_q;
  logic                  rd_cap_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      free_mem[wr_addr_i] <= wr_free_i;
    end
    if (wr_en_i && wr_cap_i) begin
      cap_mem[wr_addr_i] <= wr_cap_data_i;
    end
    rd_free_q <= free_mem[rd_addr_i];
    rd_cap_q  <= cap_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_vld_q    <= '0;
      cap_vld_q     <= '0;
      rd_free_vld_q <= 1'b0;
      rd_cap_vld_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        free_vld_q[wr_addr_i] <= 1'b1;
      end
      if (wr_en_i && wr_cap_i) begin
        cap_vld_q[wr_addr_i] <= 1'b1;
      end
      rd_free_vld_q <= free_vld_q[rd_addr_i];
      rd_cap_vld_q  <= cap_vld_q[rd_addr_i];
    end
  end

  // Mask entries never written since reset
  assign rd_free_o = rd_free_vld_q ? rd_free_q : '0;
  assign rd_cap_o  = rd_cap_vld_q  ? rd_cap_q  : '0;

endmodule

// ===== rtl/core/fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Fit block allocator
// Block table with first, best and worst fit placement; reports grant, the
// chosen block and running free and capacity totals for every request.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  ---------------------------------
//  request   in_valid_i / in_stall_o      kind_i, block_index_i, size_i
//  result    out_valid_o / out_stall_i    granted_o, chosen_block_o,
//                                         free_total_o, capacity_total_o
//  config    psel, penable, pwrite ...    fit_mode at byte address 0
//
//  A load passes through the load-write and result states before the next
//  acceptance; an allocation passes through the scan, allocation-write and
//  result states; the scan reads one block per cycle through the single
//  read port of the free-size store and feeds one shared fit comparator.
//  Reset clears the totals, the mode and the per-entry valid bits of the
//  store at once; there is no clearing pass.
//  A stalled result holds in the output register; the next request is
//  accepted meanwhile and completes once that result has been taken.
//
module fit_block_allocator #(
  parameter int unsigned NUM_BLOCKS = 8,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [fba_pkg::IDX_IN_W-1:0]  block_index_i,
  input  logic [fba_pkg::SIZE_IN_W-1:0] size_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          granted_o,
  output logic [fba_pkg::IDX_IN_W-1:0]  chosen_block_o,
  output logic [fba_pkg::SUM_W-1:0]     free_total_o,
  output logic [fba_pkg::SUM_W-1:0]     capacity_total_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fba_pkg::PADDR_W-1:0]   paddr,
  input  logic [fba_pkg::PDATA_W-1:0]   pwdata,
  output logic [fba_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  import fba_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NUM_BLOCKS);

  fba_state_e state_q, state_d;

  // Control state
  logic [MODE_W-1:0]   mode_q;
  logic [SUM_W-1:0]    free_sum_q;
  logic [SUM_W-1:0]    cap_sum_q;
  logic                found_q;
  logic                grant_q;
  logic [CNT_W-1:0]    scan_q;
  logic                out_valid_q;

  // Payload registers
  logic [SIZE_BITS-1:0] req_q;
  logic [IDX_W-1:0]     idx_q;
  logic [IDX_IN_W-1:0]  chosen_q;
  logic [IDX_W-1:0]     best_q;
  logic [SIZE_BITS-1:0] bval_q;
  logic                 out_granted_q;
  logic [IDX_IN_W-1:0]  out_chosen_q;
  logic [SUM_W-1:0]     out_free_q;
  logic [SUM_W-1:0]     out_cap_q;

  // Store interface
  logic [IDX_W-1:0]     rd_addr;
  logic [SIZE_BITS-1:0] rd_free;
  logic [SIZE_BITS-1:0] rd_cap;
  logic                 wr_en;
  logic                 wr_cap;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_free;

  logic                 accept;
  logic                 load_ok;
  logic                 mode_ok;
  logic                 result_fire;
  logic                 cfg_we;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 fits;
  logic                 take;

  // --------------------------------------------------------------------------
  // Configuration port: always ready, mode register at address 0
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == REG_FIT_MODE);
  assign prdata = (paddr == REG_FIT_MODE) ? PDATA_W'(mode_q) : '0;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  assign accept  = in_valid_i && !in_stall_o;
  assign load_ok = (32'(block_index_i) < NUM_BLOCKS);
  assign mode_ok = (mode_q == MODE_FIRST) || (mode_q == MODE_BEST) ||
                   (mode_q == MODE_WORST);
  assign result_fire = (state_q == S_RESULT) && (!out_valid_q || !out_stall_i);

  // --------------------------------------------------------------------------
  // Shared fit comparator: the block read last cycle against the request
  // and against the best candidate so far
  // --------------------------------------------------------------------------
  assign cmp_idx = IDX_W'(scan_q - CNT_W'(1));
  assign fits    = (req_q <= rd_free);
  always_comb begin
    take = 1'b0;
    if ((state_q == S_SCAN) && (scan_q != '0) && fits) begin
      priority if (!found_q) begin
        take = 1'b1;
      end else if (mode_q == MODE_BEST) begin
        take = (rd_free <= bval_q);
      end else if (mode_q == MODE_WORST) begin
        take = (rd_free >= bval_q);
      end else begin
        take = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_LOAD) begin
            state_d = load_ok ? S_LOAD_WR : S_RESULT;
          end else begin
            state_d = mode_ok ? S_SCAN : S_RESULT;
          end
        end
      end
      S_LOAD_WR:  state_d = S_RESULT;
      S_SCAN: begin
        if (scan_q == SCAN_END) begin
          state_d = S_ALLOC_WR;
        end
      end
      S_ALLOC_WR: state_d = S_RESULT;
      S_RESULT: begin
        if (result_fire) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs toward the store and the request channel
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall_o = 1'b1;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_cap     = 1'b0;
    wr_addr    = idx_q;
    wr_free    = req_q;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        // Fetch the old sizes of the load target right at acceptance
        rd_addr    = IDX_W'(block_index_i);
      end
      S_LOAD_WR: begin
        wr_en  = 1'b1;
        wr_cap = 1'b1;
      end
      S_SCAN: begin
        if (scan_q < SCAN_END) begin
          rd_addr = scan_q[IDX_W-1:0];
        end
      end
      S_ALLOC_WR: begin
        wr_en   = found_q;
        wr_addr = best_q;
        wr_free = bval_q - req_q;
      end
      S_RESULT: begin
        in_stall_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_FIRST;
      free_sum_q  <= '0;
      cap_sum_q   <= '0;
      found_q     <= 1'b0;
      grant_q     <= 1'b0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        mode_q <= pwdata[MODE_W-1:0];
      end
      if (accept) begin
        found_q <= 1'b0;
        grant_q <= 1'b0;
        scan_q  <= '0;
      end
      if (state_q == S_SCAN) begin
        scan_q <= scan_q + CNT_W'(1);
        if (take) begin
          found_q <= 1'b1;
        end
      end
      // Replace the old sizes in both totals
      if (state_q == S_LOAD_WR) begin
        free_sum_q <= free_sum_q - SUM_W'(rd_free) + SUM_W'(req_q);
        cap_sum_q  <= cap_sum_q - SUM_W'(rd_cap) + SUM_W'(req_q);
        grant_q    <= 1'b1;
      end
      if ((state_q == S_ALLOC_WR) && found_q) begin
        free_sum_q <= free_sum_q - SUM_W'(req_q);
        grant_q    <= 1'b1;
      end
      // Hold the result until the receiver takes it
      if (result_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= SIZE_BITS'(size_i);
      idx_q    <= IDX_W'(block_index_i);
      chosen_q <= block_index_i;
    end
    if (take) begin
      best_q <= cmp_idx;
      bval_q <= rd_free;
    end
    if (state_q == S_ALLOC_WR) begin
      chosen_q <= IDX_IN_W'(best_q);
    end
    if (result_fire) begin
      out_granted_q <= grant_q;
      out_chosen_q  <= grant_q ? chosen_q : '0;
      out_free_q    <= free_sum_q;
      out_cap_q     <= cap_sum_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign granted_o        = out_granted_q;
  assign chosen_block_o   = out_chosen_q;
  assign free_total_o     = out_free_q;
  assign capacity_total_o = out_cap_q;

  // --------------------------------------------------------------------------
  // Block store
  // --------------------------------------------------------------------------
  fba_block_store #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_addr_i     (rd_addr),
    .rd_free_o     (rd_free),
    .rd_cap_o      (rd_cap),
    .wr_en_i       (wr_en),
    .wr_cap_i      (wr_cap),
    .wr_addr_i     (wr_addr),
    .wr_free_i     (wr_free),
    .wr_cap_data_i (req_q)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_ON(a_accept_leaves_idle, clk_i, rst_ni, accept |=> (state_q != S_IDLE))
  `ASSERT_ON(a_result_from_seq, clk_i, rst_ni, $rose(out_valid_o) |-> $past(state_q == S_RESULT))
  `ASSERT_ON(a_scan_keeps_totals, clk_i, rst_ni, (state_q == S_SCAN) |=> $stable(free_sum_q))
  `ASSERT_ON(a_denied_block_zero, clk_i, rst_ni, (out_valid_o && !granted_o) |-> (chosen_block_o == '0))
  `ASSERT_NEVER(a_scan_in_range, clk_i, rst_ni, (state_q == S_SCAN) && (scan_q > SCAN_END))

endmodule
